@@ rtl/core/luhn_card_number_classifier_assert.svh @@
// Assertion macros shared by the card number classifier RTL.
`ifndef LUHN_CARD_NUMBER_CLASSIFIER_ASSERT_SVH
`define LUHN_CARD_NUMBER_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define LCNC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcnc assertion failed");

// Next-cycle implication, masked while reset is high.
`define LCNC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcnc assertion failed");

`endif

@@ rtl/core/lcnc_pkg.sv @@
// Types, constants and helper functions for the card number classifier.
package lcnc_pkg;

  // Width of the binary card number word.
  localparam int CARD_W = 54;
  // Decimal digits needed to hold any CARD_W-bit value.
  localparam int BCD_DIGITS = 17;
  localparam int BCD_W = 4 * BCD_DIGITS;
  // Widths of the sequencer counters and the digit count.
  localparam int BIT_CNT_W = 6;
  localparam int IDX_W = 5;
  localparam int CNT_W = 5;

  typedef logic [3:0] digit_t;
  typedef logic [1:0] class_t;

  // Class codes of the result word.
  localparam class_t CLASS_NONE = 2'd0;
  localparam class_t CLASS_LEAD4 = 2'd1;
  localparam class_t CLASS_LEAD5X = 2'd2;
  localparam class_t CLASS_LEAD3X = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  // Double a digit and fold the product back to a single digit.
  function automatic digit_t luhn_double(input digit_t d);
    logic [4:0] p;
    p = {d, 1'b0};
    if (p > 5'd9) begin
      p = p - 5'd9;
    end
    return p[3:0];
  endfunction

  // Shift-and-add-3 correction of one BCD digit.
  function automatic digit_t dabble_adj(input digit_t d);
    return (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

endpackage

@@ rtl/core/luhn_card_number_classifier.sv @@
// Card number classifier: binary to decimal conversion, Luhn check and class lookup.
//
// Pulse start with a card number while busy is low; the number is taken at that
// edge and busy rises. The binary word is turned into decimal digits by a
// shift-and-add-3 unit, one input bit per cycle, and the digits are then
// scanned one per cycle from the least significant end through a single
// mod-10 accumulator that also tracks the digit count and the two leading
// digits. A new number can be started in the cycle that done is high.
// done is high for exactly one cycle with card_class, check_passed and
// digit_count; the results stay on the ports until the next number finishes,
// but the receiver cannot stall the block, so it must take them on the strobe.
// card_class is nonzero only when the Luhn check passes and the digit count is
// at most MAX_DIGITS.
`include "luhn_card_number_classifier_assert.svh"

module luhn_card_number_classifier
  import lcnc_pkg::*;
#(
  parameter int MAX_DIGITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CARD_W-1:0] card_number,
  output logic              done,
  output class_t            card_class,
  output logic              check_passed,
  output logic [CNT_W-1:0]  digit_count
);

  state_t               state;
  state_t               state_next;
  logic [CARD_W-1:0]    bin;
  logic [BCD_W-1:0]     bcd;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [IDX_W-1:0]     idx;
  digit_t               sum;
  logic [CNT_W-1:0]     count;
  digit_t               lead_hi;
  digit_t               lead_lo;
  digit_t               prev_digit;

  logic                 accept;
  logic [BCD_W-1:0]     bcd_adj;
  digit_t               digit;
  digit_t               digit_val;
  logic [4:0]           sum_raw;
  digit_t               sum_next;
  logic [CNT_W-1:0]     count_next;
  digit_t               lead_hi_next;
  digit_t               lead_lo_next;
  logic                 pass;
  class_t               class_next;
  logic                 conv_last;
  logic                 scan_last;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign conv_last = (bit_cnt == BIT_CNT_W'(CARD_W - 1));
  assign scan_last = (idx == IDX_W'(BCD_DIGITS - 1));

  // Correct every BCD digit ahead of the shift.
  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      bcd_adj[4*k +: 4] = dabble_adj(bcd[4*k +: 4]);
    end
  end

  // Accumulate one digit: Luhn sum mod 10, digit count, leading pair.
  always_comb begin
    digit = bcd[3:0];
    digit_val = idx[0] ? luhn_double(digit) : digit;
    sum_raw = {1'b0, sum} + {1'b0, digit_val};
    sum_next = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
    count_next = count;
    lead_hi_next = lead_hi;
    lead_lo_next = lead_lo;
    if (digit != 4'd0) begin
      count_next = CNT_W'(idx) + CNT_W'(1);
      lead_hi_next = digit;
      lead_lo_next = prev_digit;
    end
    pass = (sum_next == 4'd0);
  end

  // Classify numbers that pass, with at most MAX_DIGITS digits, by length and leading digits.
  always_comb begin
    class_next = CLASS_NONE;
    if (pass && (count_next <= CNT_W'(MAX_DIGITS))) begin
      if ((count_next == CNT_W'(13) || count_next == CNT_W'(16)) && lead_hi_next == 4'd4) begin
        class_next = CLASS_LEAD4;
      end else if (count_next == CNT_W'(16) && lead_hi_next == 4'd5 &&
                   lead_lo_next >= 4'd1 && lead_lo_next <= 4'd5) begin
        class_next = CLASS_LEAD5X;
      end else if (count_next == CNT_W'(15) && lead_hi_next == 4'd3 &&
                   (lead_lo_next == 4'd4 || lead_lo_next == 4'd7)) begin
        class_next = CLASS_LEAD3X;
      end
    end
  end

  // Advance the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_last) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_SCAN) && scan_last;
    end
  end

  // Shift the conversion unit and the digit scan.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          bin <= card_number;
          bcd <= '0;
          bit_cnt <= '0;
        end
      end
      S_CONV: begin
        bcd <= {bcd_adj[BCD_W-2:0], bin[CARD_W-1]};
        bin <= {bin[CARD_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
        idx <= '0;
        sum <= 4'd0;
        count <= CNT_W'(1);
        lead_hi <= 4'd0;
        lead_lo <= 4'd0;
        prev_digit <= 4'd0;
      end
      S_SCAN: begin
        bcd <= {4'd0, bcd[BCD_W-1:4]};
        idx <= idx + IDX_W'(1);
        sum <= sum_next;
        count <= count_next;
        lead_hi <= lead_hi_next;
        lead_lo <= lead_lo_next;
        prev_digit <= digit;
      end
      default: begin
      end
    endcase
  end

  // Capture the result word on the last digit.
  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && scan_last) begin
      card_class <= class_next;
      check_passed <= pass;
      digit_count <= count_next;
    end
  end

  `LCNC_ASSERT_IMP(a_done_idle, clk, rst, done, state == S_IDLE)
  `LCNC_ASSERT_NXT(a_accept_busy, clk, rst, accept, busy && state == S_CONV)
  `LCNC_ASSERT_IMP(a_class_pass, clk, rst, done, card_class == CLASS_NONE || check_passed)
  `LCNC_ASSERT_IMP(a_count_range, clk, rst, done,
                   digit_count >= CNT_W'(1) && digit_count <= CNT_W'(BCD_DIGITS))
  `LCNC_ASSERT_NXT(a_done_pulse, clk, rst, done, !done)

endmodule

@@ test/testbench.sv @@
// Testbench for the card number classifier: directed and random numbers with a Luhn predictor.
`timescale 1ns / 100ps

module testbench;
  import lcnc_pkg::*;

  localparam int MAX_DIGITS = 16;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 500000;
  localparam int REPORT_LIMIT = 10;

  // One expected result word, tagged with the number that caused it
  typedef struct {
    logic [CARD_W-1:0] number;
    class_t            card_class;
    logic              check_passed;
    logic [CNT_W-1:0]  digit_count;
  } verdict_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CARD_W-1:0] card_number;
  logic              done;
  class_t            card_class;
  logic              check_passed;
  logic [CNT_W-1:0]  digit_count;

  verdict_t    pending_verdicts[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          idle_gaps_on;

  luhn_card_number_classifier #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .card_number(card_number),
    .done(done),
    .card_class(card_class),
    .check_passed(check_passed),
    .digit_count(digit_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Expected verdict for one card number: decimal digits, Luhn sum, class lookup
  function automatic verdict_t classify_card(input logic [CARD_W-1:0] number);
    verdict_t    v;
    logic [63:0] rest;
    int unsigned digits[20];
    int unsigned count;
    int unsigned total;
    int unsigned d;
    int unsigned lead1;
    int unsigned lead2;
    rest = 64'(number);
    count = 1;
    total = 0;
    for (int i = 0; i < 20; i++) begin
      digits[i] = int'(rest % 10);
      rest = rest / 10;
      if (digits[i] != 0) begin
        count = i + 1;
      end
    end
    // Double every second digit from the right and fold products above nine
    for (int i = 0; i < 20; i++) begin
      d = digits[i];
      if (i % 2 == 1) begin
        d = d * 2;
        if (d > 9) begin
          d = d - 9;
        end
      end
      total = total + d;
    end
    lead1 = digits[count - 1];
    lead2 = (count >= 2) ? lead1 * 10 + digits[count - 2] : lead1;
    v.number = number;
    v.check_passed = (total % 10 == 0);
    v.digit_count = CNT_W'(count);
    v.card_class = CLASS_NONE;
    if (v.check_passed && count <= MAX_DIGITS) begin
      if ((count == 13 || count == 16) && lead1 == 4) begin
        v.card_class = CLASS_LEAD4;
      end else if (count == 16 && lead2 >= 51 && lead2 <= 55) begin
        v.card_class = CLASS_LEAD5X;
      end else if (count == 15 && (lead2 == 34 || lead2 == 37)) begin
        v.card_class = CLASS_LEAD3X;
      end
    end
    return v;
  endfunction

  // Build a Luhn-valid number of the given length behind a one- or two-digit prefix
  function automatic logic [CARD_W-1:0] make_card(input int unsigned prefix,
                                                  input int unsigned length);
    logic [63:0] body;
    int unsigned plen;
    verdict_t    trial;
    plen = (prefix >= 10) ? 2 : 1;
    body = 64'(prefix);
    for (int i = plen; i < int'(length) - 1; i++) begin
      body = body * 10 + 64'($urandom_range(0, 9));
    end
    body = body * 10;
    for (int c = 0; c < 10; c++) begin
      trial = classify_card(CARD_W'(body + 64'(c)));
      if (trial.check_passed) begin
        return CARD_W'(body + 64'(c));
      end
    end
    return CARD_W'(body);
  endfunction

  // Replace the check digit by any other digit, which always breaks the sum
  function automatic logic [CARD_W-1:0] break_check(input logic [CARD_W-1:0] number);
    logic [63:0] n;
    int unsigned last;
    n = 64'(number);
    last = int'(n % 10);
    return CARD_W'(n - 64'(last) + 64'((last + $urandom_range(1, 9)) % 10));
  endfunction

  // Random number with exactly the given count of digits, no Luhn fixing
  function automatic logic [CARD_W-1:0] random_digits(input int unsigned length);
    logic [63:0] n;
    n = 64'($urandom_range(1, 9));
    for (int i = 1; i < int'(length); i++) begin
      n = n * 10 + 64'($urandom_range(0, 9));
    end
    return CARD_W'(n);
  endfunction

  // Send one word: optional idle gap after the block frees up, then hold start until taken
  task automatic send_number(input logic [CARD_W-1:0] number);
    int unsigned gap;
    gap = idle_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      do begin
        @(negedge clk);
        start <= 1'b0;
      end while (busy);
      repeat (gap - 1) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start <= 1'b1;
    card_number <= number;
    do @(posedge clk); while (busy);
    pending_verdicts.push_back(classify_card(number));
  endtask

  // Drop start and hold until every expected word has come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got, input logic [CARD_W-1:0] number);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch on %s for card %0d: expected %0d, got %0d", field, number, want,
               got);
    end
  endtask

  // Compare each strobed result word with the oldest expectation
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("result word with nothing pending: class %0d, pass %0d, digits %0d",
                   card_class, check_passed, digit_count);
        end
      end else begin
        want = pending_verdicts.pop_front();
        if (card_class !== want.card_class) begin
          report_mismatch("card_class", want.card_class, card_class, want.number);
        end
        if (check_passed !== want.check_passed) begin
          report_mismatch("check_passed", want.check_passed, check_passed, want.number);
        end
        if (digit_count !== want.digit_count) begin
          report_mismatch("digit_count", want.digit_count, digit_count, want.number);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Zero, one digit, digit-count steps, the widest values and alternating bit patterns
  task automatic test_extremes();
    send_number('0);
    send_number(CARD_W'(1));
    send_number(CARD_W'(9));
    send_number(CARD_W'(10));
    send_number(CARD_W'(99));
    send_number(CARD_W'(64'd1000000000000000));
    send_number(CARD_W'(64'd9999999999999999));
    send_number(CARD_W'(64'd10000000000000000));
    send_number({CARD_W{1'b1}});
    send_number(CARD_W'(54'h2AAAAAAAAAAAAA));
    send_number(CARD_W'(54'h15555555555555));
  endtask

  // One valid number per recognized prefix group and length, with 51 and 55 for the 51 to 55 range
  task automatic test_card_classes();
    send_number(make_card(4, 13));
    send_number(make_card(4, 16));
    send_number(make_card(51, 16));
    send_number(make_card(55, 16));
    send_number(make_card(34, 15));
    send_number(make_card(37, 15));
  endtask

  // Failed check, right prefix with wrong length, near-miss prefixes, too many digits
  task automatic test_rejections();
    send_number(break_check(make_card(4, 16)));
    send_number(make_card(4, 14));
    send_number(make_card(4, 15));
    send_number(make_card(56, 16));
    send_number(make_card(50, 16));
    send_number(make_card(35, 15));
    send_number(make_card(10, 17));
  endtask

  // Mostly well-formed cards with random bodies, the rest broken cards and raw noise
  task automatic test_random_mix();
    int unsigned       kind;
    int unsigned       prefix;
    int unsigned       length;
    logic [CARD_W-1:0] number;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Pick idle gaps or back-to-back bursts anew every 25 words
      if (n % 25 == 0) begin
        idle_gaps_on = ($urandom_range(0, 3) != 0);
      end
      if (n == RANDOM_ITEMS / 2) begin
        wait_drained();
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        case ($urandom_range(0, 3))
          0: number = make_card(4, ($urandom_range(0, 1) != 0) ? 13 : 16);
          1: number = make_card($urandom_range(51, 55), 16);
          2: number = make_card(($urandom_range(0, 1) != 0) ? 34 : 37, 15);
          default: number = make_card($urandom_range(1, 9), $urandom_range(2, 16));
        endcase
      end else if (kind < 70) begin
        prefix = $urandom_range(1, 99);
        length = $urandom_range((prefix >= 10) ? 3 : 2, 16);
        number = make_card(prefix, length);
        if ($urandom_range(0, 1) != 0) begin
          number = break_check(number);
        end
      end else if (kind < 85) begin
        number = random_digits($urandom_range(1, 16));
      end else begin
        number = CARD_W'({$urandom, $urandom});
      end
      send_number(number);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    card_number = '0;
    mismatch_count = 0;
    cycle_count = 0;
    idle_gaps_on = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_card_classes();
    test_rejections();
    wait_drained();
    test_random_mix();

    // Drain, then watch for stray strobes
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ luhn_card_number_classifier.f @@
+incdir+rtl/core
rtl/core/lcnc_pkg.sv
rtl/core/luhn_card_number_classifier.sv
test/testbench.sv
